>>> rtl/core/ack_reply_byte_parser_macros.svh
// Assertion macros used by the checker of the ack reply byte parser.
`ifndef ACK_REPLY_BYTE_PARSER_MACROS_SVH
`define ACK_REPLY_BYTE_PARSER_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ABRP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in ack reply byte parser checker");

// Check a property on every clock edge, reset included.
`define ABRP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed in ack reply byte parser checker");

`endif

>>> rtl/core/abrp_pkg.sv
// Package with constants and byte codes of the ack reply byte parser.
package abrp_pkg;

    localparam int STATUS_BITS = 16;
    localparam int NIBBLES     = STATUS_BITS / 4;
    localparam int CNT_W       = $clog2(NIBBLES + 1);

    // Status register after reset: bit 8 set, motor stopped.
    localparam logic [31:0] STATUS_RESET_FULL = 32'h0000_0100;
    localparam logic [STATUS_BITS-1:0] STATUS_RESET = STATUS_RESET_FULL[STATUS_BITS-1:0];

    localparam logic [7:0] BYTE_STX   = 8'h02;
    localparam logic [7:0] BYTE_ETX   = 8'h03;
    localparam logic [7:0] BYTE_ACK   = 8'h06;
    localparam logic [7:0] BYTE_MINUS = 8'h2D;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_NINE  = 8'h39;

    // Letter nibbles come from byte minus 0x37; only the low four bits count.
    localparam logic [3:0] LETTER_BIAS = 4'h7;

endpackage

>>> rtl/core/ack_reply_byte_parser.sv
// Top level of the ack reply byte parser: byte input register, parse logic, result register.
//
// Usage:
//   Input channel: i_valid / o_ready carry one received byte (i_rx_byte) per item.
//   Output channel: o_valid / i_ready carry one result item per input item:
//   o_status_word, o_reply_number, o_number_valid, o_reply_complete, o_motor_running.
//   An ACK byte opens a reply and arms capture of the status nibbles; digit bytes
//   feed the decimal accumulator; ETX closes the reply and pulses o_reply_complete.
//   The input register takes the byte at the accepting edge; the result register loads it
//   once the result register is free or being emptied. Throughput: one item per cycle
//   while the receiver keeps i_ready high; the parse state updates in the cycle that moves
//   an item from the input register to the result register.
//   Stall: while the receiver holds i_ready low, the result register holds its item
//   and the input register still takes one more byte; o_ready falls only when both
//   registers are full.
//   Reset (synchronous, active low): both registers empty, reply closed, capture
//   closed, status 0x0100 (motor stopped), value zero, numeric and negative clear.
module ack_reply_byte_parser
    import abrp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_status_word,
    output logic signed [31:0] o_reply_number,
    output logic               o_number_valid,
    output logic               o_reply_complete,
    output logic               o_motor_running
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Parse state
    logic                   r_in_reply,  n_in_reply;
    logic [CNT_W-1:0]       r_cnt,       n_cnt;
    logic [STATUS_BITS-1:0] r_status,    n_status;
    logic [31:0]            r_value,     n_value;
    logic                   r_numeric,   n_numeric;
    logic                   r_negative,  n_negative;
    logic                   n_done;

    // Result register
    logic        r_out_valid;
    logic [15:0] r_out_status;
    logic [31:0] r_out_value;
    logic        r_out_numeric;
    logic        r_out_done;
    logic        r_out_running;

    logic                      advance;
    logic                      is_digit;
    logic                      capture;
    logic [3:0]                nibble;
    logic [STATUS_BITS+15:0]   status_ext;

    // Move the held byte on whenever the result register is free or being emptied.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    assign is_digit = (r_in_byte >= BYTE_ZERO) && (r_in_byte <= BYTE_NINE);
    assign capture  = r_in_reply && (r_cnt < CNT_W'(NIBBLES));
    // Digit low nibble equals byte minus 0x30; letters take the low bits of byte minus 0x37.
    assign nibble   = is_digit ? r_in_byte[3:0] : (r_in_byte[3:0] - LETTER_BIAS);

    always_comb begin
        n_in_reply = r_in_reply;
        n_cnt      = r_cnt;
        n_status   = r_status;
        n_value    = r_value;
        n_numeric  = r_numeric;
        n_negative = r_negative;
        n_done     = 1'b0;
        unique case (r_in_byte)
            BYTE_STX: begin
                // STX leaves everything alone
            end
            BYTE_ETX: begin
                if (r_in_reply) begin
                    if (r_negative && r_numeric) begin
                        n_value = 32'd0 - r_value;
                    end
                    n_done = 1'b1;
                end
                n_in_reply = 1'b0;
            end
            BYTE_ACK: begin
                n_in_reply = 1'b1;
                n_cnt      = '0;
                n_value    = '0;
                n_numeric  = 1'b0;
                n_negative = 1'b0;
            end
            default: begin
                // Fill status nibbles most significant first.
                if (capture) begin
                    for (int i = 0; i < NIBBLES; i++) begin
                        if (r_cnt == CNT_W'(NIBBLES - 1 - i)) begin
                            n_status[i*4 +: 4] = nibble;
                        end
                    end
                    n_cnt = r_cnt + CNT_W'(1);
                end
                if (is_digit) begin
                    n_value   = (r_value << 3) + (r_value << 1) + {28'd0, r_in_byte[3:0]};
                    n_numeric = 1'b1;
                end else begin
                    n_numeric = 1'b0;
                end
                if (r_in_byte == BYTE_MINUS) begin
                    n_negative = 1'b1;
                end
            end
        endcase
    end

    // Zero-extend the status so the low 16 bits and bit 8 always exist.
    assign status_ext = {16'd0, n_status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_in_reply  <= 1'b0;
            r_cnt       <= CNT_W'(NIBBLES);
            r_status    <= STATUS_RESET;
            r_value     <= '0;
            r_numeric   <= 1'b0;
            r_negative  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_in_reply  <= n_in_reply;
                r_cnt       <= n_cnt;
                r_status    <= n_status;
                r_value     <= n_value;
                r_numeric   <= n_numeric;
                r_negative  <= n_negative;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: load on handshake, no reset needed.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (advance) begin
            r_out_status  <= status_ext[15:0];
            r_out_value   <= n_value;
            r_out_numeric <= n_numeric;
            r_out_done    <= n_done;
            r_out_running <= !status_ext[8];
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status_word    = r_out_status;
    assign o_reply_number   = r_out_value;
    assign o_number_valid   = r_out_numeric;
    assign o_reply_complete = r_out_done;
    assign o_motor_running  = r_out_running;

endmodule

>>> rtl/core/abrp_checker.sv
// Port-level checker of the ack reply byte parser and its bind.
`include "ack_reply_byte_parser_macros.svh"

module abrp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic [15:0]        o_status_word,
    input logic signed [31:0] o_reply_number,
    input logic               o_reply_complete,
    input logic               o_motor_running
);

    // Reset empties the result register.
    `ABRP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid)

    // Input back-pressure only when a result is waiting.
    `ABRP_ASSERT_IMPL(a_ready_low_full, i_clk, i_rst_n, !o_ready, o_valid)

    // Motor flag follows status bit 8 in every result.
    `ABRP_ASSERT_IMPL(a_motor_bit, i_clk, i_rst_n, o_valid, o_motor_running == !o_status_word[8])

    // Hold a stalled result.
    `ABRP_ASSERT_IMPL(a_stall_hold, i_clk, i_rst_n, ##1 ($past(o_valid) && !$past(i_ready)), o_valid && $stable(o_reply_number) && $stable(o_status_word) && $stable(o_reply_complete))

endmodule

bind ack_reply_byte_parser abrp_checker u_abrp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_status_word    (o_status_word),
    .o_reply_number   (o_reply_number),
    .o_reply_complete (o_reply_complete),
    .o_motor_running  (o_motor_running)
);
